// File: rtl/fmp_pkg.sv
// Shared constants for the Fibonacci modular matrix power block.
package fmp_pkg;
    localparam int DEF_INDEX_WIDTH = 64;
    localparam int DEF_MOD_WIDTH   = 32;
    localparam int INDEX_PORT_W    = 63;
    localparam int VALUE_PORT_W    = 32;
    localparam int MODULUS_RESET   = 2022;
endpackage

// File: rtl/fibonacci_mod_matrix_power.sv
// Top level: F(n) mod m by square-and-multiply of the 2x2 Fibonacci matrix.
//
// Input channel req_valid/req_stall carries fib_index; output channel
// rsp_valid/rsp_stall carries fib_value. An item moves on a rising edge with
// valid high and stall low. The modulus register is written by modulus_we with
// modulus_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this. Zero means 2^MOD_WIDTH. One item walks
// INDEX_WIDTH index bits, MSB first. Each bit squares the accumulator matrix:
// four entries, each a sum of two modular products formed by one shared
// shift-add-reduce unit after a load step, then a base-matrix step when the
// bit is set and a step to advance to the next bit. The block takes no new
// item before the result of the last one has entered the output register.
// req_stall is high from acceptance until the result enters the output register.
// The output register holds a finished item while the receiver stalls, and a
// new item may be accepted meanwhile; a second result waits in the sequencer
// until the first is taken.
// Reset clears the sequencer and output valid and sets the modulus to 2022.
module fibonacci_mod_matrix_power #(
    parameter int INDEX_WIDTH = fmp_pkg::DEF_INDEX_WIDTH,
    parameter int MOD_WIDTH   = fmp_pkg::DEF_MOD_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             modulus_we,
    input  logic [fmp_pkg::VALUE_PORT_W-1:0] modulus_wdata,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [fmp_pkg::INDEX_PORT_W-1:0] fib_index,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [fmp_pkg::VALUE_PORT_W-1:0] fib_value
);
    import fmp_pkg::*;

    localparam int IW  = INDEX_WIDTH;
    localparam int MW  = MOD_WIDTH;
    localparam int ICW = (IW > 1) ? $clog2(IW) : 1;
    localparam int SCW = $clog2(MW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_BASE = 3'd3;
    localparam logic [2:0] ST_NEXT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]      state_reg;
    logic [MW-1:0]   mod_reg;
    logic [IW-1:0]   ix_reg;
    logic [ICW-1:0]  icnt_reg;
    logic [SCW-1:0]  scnt_reg;
    logic [1:0]      ent_reg;
    logic [MW-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic [MW-1:0]   na_reg, nb_reg, nc_reg;
    logic [MW-1:0]   y1_reg, y2_reg;
    logic [MW-1:0]   r_reg;
    logic [MW-1:0]   r_next;
    logic            rsp_valid_reg;
    logic [MW-1:0]   rsp_data_reg;

    logic [MW:0]     mod_eff;
    logic [MW-1:0]   one_val;
    logic [MW-1:0]   x1, x2, ld_y1, ld_y2;
    logic [MW+1:0]   t0, t1, t2;
    logic [MW+1:0]   sa, sc;
    logic [63:0]     ix_ext;
    logic            rsp_load;

    // Zero modulus stands for 2^MW
    assign mod_eff = {(mod_reg == '0), mod_reg};
    assign one_val = (mod_reg == MW'(1)) ? '0 : MW'(1);
    assign ix_ext  = {1'b0, fib_index};

    // Move a finished item into the output register when it is free or being taken
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    function automatic logic [MW+1:0] red(input logic [MW+1:0] v, input logic [MW:0] m);
        logic [MW+1:0] mx;
        mx = {1'b0, m};
        return (v >= mx) ? v - mx : v;
    endfunction

    // Operand select: row from entry bit 1, column from entry bit 0
    always_comb
    begin
        x1    = ent_reg[1] ? c_reg : a_reg;
        x2    = ent_reg[1] ? d_reg : b_reg;
        ld_y1 = ent_reg[0] ? b_reg : a_reg;
        ld_y2 = ent_reg[0] ? d_reg : c_reg;
    end

    // Shared unit: double, then add each selected multiplicand, reducing each time
    always_comb
    begin
        t0 = red({1'b0, r_reg, 1'b0}, mod_eff);
        t1 = y1_reg[MW-1] ? red(t0 + {2'b00, x1}, mod_eff) : t0;
        t2 = y2_reg[MW-1] ? red(t1 + {2'b00, x2}, mod_eff) : t1;
        r_next = t2[MW-1:0];
        sa = red({2'b00, a_reg} + {2'b00, b_reg}, mod_eff);
        sc = red({2'b00, c_reg} + {2'b00, d_reg}, mod_eff);
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MW'(MODULUS_RESET);
        else if (modulus_we)
            mod_reg <= modulus_wdata[MW-1:0];
    end

    // Sequencer and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (req_valid)
                        state_reg <= ST_LOAD;
                ST_LOAD:
                    state_reg <= ST_MUL;
                ST_MUL:
                    if (scnt_reg == '0)
                    begin
                        if (ent_reg == 2'd3)
                            state_reg <= ix_reg[IW-1] ? ST_BASE : ST_NEXT;
                        else
                            state_reg <= ST_LOAD;
                    end
                ST_BASE:
                    state_reg <= ST_NEXT;
                ST_NEXT:
                    state_reg <= (icnt_reg == '0) ? ST_DONE : ST_LOAD;
                ST_DONE:
                    if (rsp_load)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                begin
                    ix_reg   <= ix_ext[IW-1:0];
                    icnt_reg <= ICW'(IW - 1);
                    ent_reg  <= 2'd0;
                    a_reg    <= one_val;
                    b_reg    <= '0;
                    c_reg    <= '0;
                    d_reg    <= one_val;
                end
            ST_LOAD:
            begin
                r_reg    <= '0;
                y1_reg   <= ld_y1;
                y2_reg   <= ld_y2;
                scnt_reg <= SCW'(MW - 1);
            end
            ST_MUL:
            begin
                r_reg    <= r_next;
                y1_reg   <= {y1_reg[MW-2:0], 1'b0};
                y2_reg   <= {y2_reg[MW-2:0], 1'b0};
                scnt_reg <= scnt_reg - 1'b1;
                if (scnt_reg == '0)
                begin
                    ent_reg <= ent_reg + 1'b1;
                    case (ent_reg)
                        2'd0: na_reg <= r_next;
                        2'd1: nb_reg <= r_next;
                        2'd2: nc_reg <= r_next;
                        default:
                        begin
                            a_reg <= na_reg;
                            b_reg <= nb_reg;
                            c_reg <= nc_reg;
                            d_reg <= r_next;
                        end
                    endcase
                end
            end
            ST_BASE:
            begin
                a_reg <= sa[MW-1:0];
                b_reg <= a_reg;
                c_reg <= sc[MW-1:0];
                d_reg <= c_reg;
            end
            ST_NEXT:
            begin
                ix_reg   <= ix_reg << 1;
                icnt_reg <= icnt_reg - 1'b1;
            end
            ST_DONE:
                if (rsp_load)
                    rsp_data_reg <= b_reg;
            default:
                ;
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign fib_value = VALUE_PORT_W'(rsp_data_reg);
endmodule

// File: rtl/fmp_checker.sv
// Port-level checker for the Fibonacci modular matrix power block, with its bind.
module fmp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_stall,
    input logic                             rsp_valid,
    input logic                             rsp_stall,
    input logic [fmp_pkg::VALUE_PORT_W-1:0] fib_value
);
    import fmp_pkg::*;

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(fib_value))
        else $error("stalled result changed");

    // Go busy after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("not busy after accept");

    // A new result only follows busy work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without work");
endmodule

bind fibonacci_mod_matrix_power fmp_checker u_fmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .fib_value (fib_value)
);
